>>> hw/rtl/kvclp_pkg.sv
// ----------------------------------------------------------------------------
// kvclp_pkg
// shared types and constants of the key/value command line parser
// ----------------------------------------------------------------------------
package kvclp_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned STATUS_W    = 2;
    localparam int unsigned KIND_W      = 3;
    localparam int unsigned FRAME_CNT_W = 7;
    localparam int unsigned KEY_MAX     = 5;
    localparam int unsigned KEY_IDX_W   = 3;
    localparam int unsigned KEY_LEN_W   = 3;
    localparam int unsigned DIGIT_SUM_W = 12;

    localparam logic [KEY_LEN_W-1:0] KEY_BAD = 3'd6;

    localparam logic [BYTE_W-1:0] VALUE_LIMIT_RESET = 8'd180;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_MALFORMED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_UNKNOWN   = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd3;

    localparam logic [KIND_W-1:0] KIND_YAW        = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PITCH      = 3'd1;
    localparam logic [KIND_W-1:0] KIND_MOTOR      = 3'd2;
    localparam logic [KIND_W-1:0] KIND_PUMP       = 3'd3;
    localparam logic [KIND_W-1:0] KIND_AUTO_WATER = 3'd4;
    localparam logic [KIND_W-1:0] KIND_THRESHOLD  = 3'd5;

    localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_VT    = 8'h0B;
    localparam logic [BYTE_W-1:0] CHAR_FF    = 8'h0C;
    localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [BYTE_W-1:0] CHAR_COLON = 8'h3A;
    localparam logic [BYTE_W-1:0] CHAR_EQUAL = 8'h3D;
    localparam logic [BYTE_W-1:0] CHAR_UC_A  = 8'h41;
    localparam logic [BYTE_W-1:0] CHAR_UC_Z  = 8'h5A;
    localparam logic [BYTE_W-1:0] CASE_DIFF  = 8'h20;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [KIND_W-1:0]   kind;
        logic [BYTE_W-1:0]   cmd_value;
    } result_t;

endpackage

>>> hw/rtl/kvclp_parse.sv
// ----------------------------------------------------------------------------
// kvclp_parse
// per-byte line parse state, value limit register and end-of-line or overflow result
// ----------------------------------------------------------------------------
module kvclp_parse #(
    parameter int unsigned MAX_FRAME_LEN = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [kvclp_pkg::BYTE_W-1:0]  cfg_data,
    input  logic                          byte_accept,
    input  logic [kvclp_pkg::BYTE_W-1:0]  rx_byte,
    output logic                          res_valid,
    output kvclp_pkg::result_t            res
);

    typedef enum logic [2:0] {
        PH_LEAD    = 3'd0,
        PH_KEY     = 3'd1,
        PH_VSTART  = 3'd2,
        PH_VDIGITS = 3'd3,
        PH_VDONE   = 3'd4
    } phase_t;

    localparam logic [kvclp_pkg::FRAME_CNT_W-1:0] FRAME_MAX =
        kvclp_pkg::FRAME_CNT_W'(MAX_FRAME_LEN);

    logic [kvclp_pkg::BYTE_W-1:0]      value_limit_reg;
    logic [kvclp_pkg::FRAME_CNT_W-1:0] frame_count_reg, frame_count_next;
    phase_t                            phase_reg, phase_next;
    logic [kvclp_pkg::BYTE_W-1:0]      key_chars_reg [kvclp_pkg::KEY_MAX];
    logic [kvclp_pkg::KEY_LEN_W-1:0]   key_length_reg, key_length_next;
    logic                              key_space_reg, key_space_next;
    logic [kvclp_pkg::BYTE_W-1:0]      magnitude_reg, magnitude_next;
    logic                              negative_reg, negative_next;
    logic                              nonzero_reg, nonzero_next;
    logic                              text_seen_reg, text_seen_next;
    logic                              ended_reg, ended_next;

    logic                              key_we;
    logic [kvclp_pkg::BYTE_W-1:0]      key_char;
    logic                              is_ws, is_sep, is_digit, is_sign;
    logic [kvclp_pkg::DIGIT_SUM_W-1:0] digit_sum;
    logic [kvclp_pkg::BYTE_W-1:0]      digit_mag;
    logic                              digit_nz;
    kvclp_pkg::result_t                line_res;
    logic                              found;
    logic [kvclp_pkg::KIND_W-1:0]      found_kind;

    // character classes
    always_comb begin
        is_ws    = (rx_byte == kvclp_pkg::CHAR_SPACE) || (rx_byte == kvclp_pkg::CHAR_TAB)
                || (rx_byte == kvclp_pkg::CHAR_VT) || (rx_byte == kvclp_pkg::CHAR_FF);
        is_sep   = (rx_byte == kvclp_pkg::CHAR_COLON) || (rx_byte == kvclp_pkg::CHAR_EQUAL);
        is_digit = (rx_byte >= kvclp_pkg::CHAR_ZERO) && (rx_byte <= kvclp_pkg::CHAR_NINE);
        is_sign  = (rx_byte == kvclp_pkg::CHAR_PLUS) || (rx_byte == kvclp_pkg::CHAR_MINUS);
        if ((rx_byte >= kvclp_pkg::CHAR_UC_A) && (rx_byte <= kvclp_pkg::CHAR_UC_Z)) begin
            key_char = rx_byte + kvclp_pkg::CASE_DIFF;
        end else begin
            key_char = rx_byte;
        end
    end

    // saturating decimal accumulate
    always_comb begin
        digit_sum = {1'b0, magnitude_reg, 3'b000} + {3'b000, magnitude_reg, 1'b0}
                  + kvclp_pkg::DIGIT_SUM_W'(rx_byte - kvclp_pkg::CHAR_ZERO);
        digit_mag = (digit_sum > kvclp_pkg::DIGIT_SUM_W'(8'hFF)) ? 8'hFF
                  : digit_sum[kvclp_pkg::BYTE_W-1:0];
        digit_nz  = (rx_byte != kvclp_pkg::CHAR_ZERO);
    end

    // key lookup
    always_comb begin
        found      = 1'b0;
        found_kind = kvclp_pkg::KIND_YAW;
        unique case (key_length_reg)
            3'd1: begin
                found = 1'b1;
                unique case (key_chars_reg[0])
                    8'h79:   found_kind = kvclp_pkg::KIND_YAW;
                    8'h70:   found_kind = kvclp_pkg::KIND_PITCH;
                    8'h6D:   found_kind = kvclp_pkg::KIND_MOTOR;
                    8'h63:   found_kind = kvclp_pkg::KIND_AUTO_WATER;
                    8'h62:   found_kind = kvclp_pkg::KIND_THRESHOLD;
                    default: found = 1'b0;
                endcase
            end
            3'd3: begin
                found      = {key_chars_reg[0], key_chars_reg[1], key_chars_reg[2]} == "yaw";
                found_kind = kvclp_pkg::KIND_YAW;
            end
            3'd4: begin
                found      = {key_chars_reg[0], key_chars_reg[1], key_chars_reg[2],
                              key_chars_reg[3]} == "pump";
                found_kind = kvclp_pkg::KIND_PUMP;
            end
            3'd5: begin
                if ({key_chars_reg[0], key_chars_reg[1], key_chars_reg[2],
                     key_chars_reg[3], key_chars_reg[4]} == "pitch") begin
                    found      = 1'b1;
                    found_kind = kvclp_pkg::KIND_PITCH;
                end else if ({key_chars_reg[0], key_chars_reg[1], key_chars_reg[2],
                              key_chars_reg[3], key_chars_reg[4]} == "motor") begin
                    found      = 1'b1;
                    found_kind = kvclp_pkg::KIND_MOTOR;
                end
            end
            default: found = 1'b0;
        endcase
    end

    // end-of-line result
    always_comb begin
        line_res = '0;
        if ((phase_reg == PH_LEAD) || (phase_reg == PH_KEY) || (key_length_reg == '0)
                || !text_seen_reg) begin
            line_res.status = kvclp_pkg::STATUS_MALFORMED;
        end else if (!found) begin
            line_res.status = kvclp_pkg::STATUS_UNKNOWN;
        end else begin
            line_res.status = kvclp_pkg::STATUS_OK;
            line_res.kind   = found_kind;
            if ((found_kind == kvclp_pkg::KIND_PUMP)
                    || (found_kind == kvclp_pkg::KIND_AUTO_WATER)) begin
                line_res.cmd_value = {7'd0, nonzero_reg};
            end else if (negative_reg) begin
                line_res.cmd_value = '0;
            end else if (magnitude_reg > value_limit_reg) begin
                line_res.cmd_value = value_limit_reg;
            end else begin
                line_res.cmd_value = magnitude_reg;
            end
        end
    end

    // next state
    always_comb begin
        frame_count_next = frame_count_reg;
        phase_next       = phase_reg;
        key_length_next  = key_length_reg;
        key_space_next   = key_space_reg;
        magnitude_next   = magnitude_reg;
        negative_next    = negative_reg;
        nonzero_next     = nonzero_reg;
        text_seen_next   = text_seen_reg;
        ended_next       = ended_reg;
        key_we           = 1'b0;
        res_valid        = 1'b0;
        res              = '0;

        if (byte_accept && (rx_byte != kvclp_pkg::CHAR_CR)) begin
            if ((rx_byte == kvclp_pkg::CHAR_LF) || (frame_count_reg >= FRAME_MAX)) begin
                if ((rx_byte != kvclp_pkg::CHAR_LF) || (frame_count_reg != '0)) begin
                    res_valid        = 1'b1;
                    res              = line_res;
                    if (rx_byte != kvclp_pkg::CHAR_LF) begin
                        res        = '0;
                        res.status = kvclp_pkg::STATUS_OVERFLOW;
                    end
                    frame_count_next = '0;
                    phase_next       = PH_LEAD;
                    key_length_next  = '0;
                    key_space_next   = 1'b0;
                    magnitude_next   = '0;
                    negative_next    = 1'b0;
                    nonzero_next     = 1'b0;
                    text_seen_next   = 1'b0;
                    ended_next       = 1'b0;
                end
            end else begin
                frame_count_next = frame_count_reg + 1'b1;
                if (!ended_reg) begin
                    if (rx_byte == kvclp_pkg::CHAR_NUL) begin
                        ended_next = 1'b1;
                    end else begin
                        unique case (phase_reg)
                            PH_LEAD, PH_KEY: begin
                                if (is_ws) begin
                                    if (phase_reg == PH_KEY) begin
                                        key_space_next = 1'b1;
                                    end
                                end else if (is_sep) begin
                                    phase_next = PH_VSTART;
                                end else begin
                                    phase_next = PH_KEY;
                                    if ((phase_reg == PH_KEY) && key_space_reg) begin
                                        key_length_next = kvclp_pkg::KEY_BAD;
                                    end else if (key_length_reg
                                            < kvclp_pkg::KEY_LEN_W'(kvclp_pkg::KEY_MAX)) begin
                                        key_we          = 1'b1;
                                        key_length_next = key_length_reg + 1'b1;
                                    end else begin
                                        key_length_next = kvclp_pkg::KEY_BAD;
                                    end
                                end
                            end
                            PH_VSTART: begin
                                if (!is_ws) begin
                                    text_seen_next = 1'b1;
                                    if (is_sign) begin
                                        negative_next = (rx_byte == kvclp_pkg::CHAR_MINUS);
                                        phase_next    = PH_VDIGITS;
                                    end else if (is_digit) begin
                                        magnitude_next = digit_mag;
                                        nonzero_next   = nonzero_reg | digit_nz;
                                        phase_next     = PH_VDIGITS;
                                    end else begin
                                        phase_next = PH_VDONE;
                                    end
                                end
                            end
                            PH_VDIGITS: begin
                                if (is_digit) begin
                                    magnitude_next = digit_mag;
                                    nonzero_next   = nonzero_reg | digit_nz;
                                end else begin
                                    phase_next = PH_VDONE;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            value_limit_reg <= kvclp_pkg::VALUE_LIMIT_RESET;
            frame_count_reg <= '0;
            phase_reg       <= PH_LEAD;
            key_length_reg  <= '0;
            key_space_reg   <= 1'b0;
            magnitude_reg   <= '0;
            negative_reg    <= 1'b0;
            nonzero_reg     <= 1'b0;
            text_seen_reg   <= 1'b0;
            ended_reg       <= 1'b0;
        end else begin
            if (cfg_we) begin
                value_limit_reg <= cfg_data;
            end
            frame_count_reg <= frame_count_next;
            phase_reg       <= phase_next;
            key_length_reg  <= key_length_next;
            key_space_reg   <= key_space_next;
            magnitude_reg   <= magnitude_next;
            negative_reg    <= negative_next;
            nonzero_reg     <= nonzero_next;
            text_seen_reg   <= text_seen_next;
            ended_reg       <= ended_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (key_we) begin
            key_chars_reg[key_length_reg[kvclp_pkg::KEY_IDX_W-1:0]] <= key_char;
        end
    end

`ifndef NO_ASSERTIONS
    a_frame_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        frame_count_reg <= FRAME_MAX)
        else $error("line length beyond limit");

    a_key_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        key_length_reg <= kvclp_pkg::KEY_BAD)
        else $error("key length out of range");

    a_result_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |=> (frame_count_reg == '0) && (key_length_reg == '0) && !ended_reg)
        else $error("line state not cleared after result");

    a_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && (res.status != kvclp_pkg::STATUS_OK))
            |-> (res.kind == '0) && (res.cmd_value == '0))
        else $error("fields set on failed line");
`endif

endmodule

>>> hw/rtl/kvclp_out.sv
// ----------------------------------------------------------------------------
// kvclp_out
// result register holding one transaction for the downstream side
// ----------------------------------------------------------------------------
module kvclp_out (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  kvclp_pkg::result_t  load_data,
    output logic                space,
    output logic                m_valid,
    input  logic                m_ready,
    output kvclp_pkg::result_t  m_data
);

    logic               valid_reg;
    kvclp_pkg::result_t data_reg;

    assign space   = !valid_reg || m_ready;
    assign m_valid = valid_reg;
    assign m_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_data;
        end
    end

endmodule

>>> hw/rtl/key_value_command_line_parser.sv
// ----------------------------------------------------------------------------
// key_value_command_line_parser
// byte-wise key:value command line parser with one result per line
// ----------------------------------------------------------------------------
// Takes one received byte per cycle and returns one result per non-empty line
// (or per overflowing byte). Each accepted byte updates the registered line parse
// state, and a result lands in the output register on the same edge and
// is offered on m_* from the next cycle. Throughput is one byte per cycle,
// limited only by the single output register: s_ready drops while a result
// waits and m_ready is low. cfg_ready is always high; value_limit resets to
// 180 and should only be written while the parser is idle.
module key_value_command_line_parser #(
    parameter int unsigned MAX_FRAME_LEN = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [kvclp_pkg::BYTE_W-1:0]        cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [kvclp_pkg::BYTE_W-1:0]        s_rx_byte,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [kvclp_pkg::STATUS_W-1:0]      m_status,
    output logic [kvclp_pkg::KIND_W-1:0]        m_kind,
    output logic [kvclp_pkg::BYTE_W-1:0]        m_cmd_value
);

    logic               space;
    logic               res_valid;
    kvclp_pkg::result_t res;
    kvclp_pkg::result_t m_data;

    assign cfg_ready = 1'b1;
    assign s_ready   = space;

    kvclp_parse #(
        .MAX_FRAME_LEN (MAX_FRAME_LEN)
    ) u_parse (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_data    (cfg_data),
        .byte_accept (s_valid && s_ready),
        .rx_byte     (s_rx_byte),
        .res_valid   (res_valid),
        .res         (res)
    );

    kvclp_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (res_valid),
        .load_data (res),
        .space     (space),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    assign m_status    = m_data.status;
    assign m_kind      = m_data.kind;
    assign m_cmd_value = m_data.cmd_value;

endmodule
